// File: rtl/ldfc_pkg.sv
// Package for the LED driver frame composer.
// Types, frame constants and register indexes; no dependencies.
`default_nettype none
package ldfc_pkg;

  localparam int NUM_CH    = 5;
  localparam int FRAME_LEN = 12;
  localparam int CNT_W     = $clog2(2 * FRAME_LEN);
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int CH_W      = $clog2(NUM_CH);
  localparam int PADDR_W   = 4;

  localparam logic [7:0] ADDR_STANDBY = 8'h00;
  localparam logic [7:0] ADDR_COLOR   = 8'h08;
  localparam logic [7:0] ADDR_WHITE   = 8'h10;
  localparam logic [7:0] ADDR_ALL     = 8'h18;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MODEL_BASE    = 2'd0;
  localparam logic [1:0] REG_COLOR_CURRENT = 2'd1;
  localparam logic [1:0] REG_WHITE_CURRENT = 2'd2;

  typedef logic [9:0] level_t;

  typedef enum logic [1:0] {
    KIND_WHITE,
    KIND_COLOR,
    KIND_MIXED,
    KIND_OFF
  } kind_t;

  typedef struct packed {
    logic changed;
    logic nonzero;
  } lane_flags_t;

  typedef struct packed {
    kind_t                     kind;
    logic [NUM_CH-1:0][9:0]    levels;
  } frame_desc_t;

  typedef struct packed {
    logic [7:0] model_base;
    logic [3:0] color_current;
    logic [3:0] white_current;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/ldfc_if.sv
// Valid/ready channel interfaces of the LED driver frame composer.
// Input carries five levels, output carries one frame byte; no dependencies.
`default_nettype none
interface ldfc_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] red_level;
  logic [9:0] green_level;
  logic [9:0] blue_level;
  logic [9:0] cold_level;
  logic [9:0] warm_level;

  modport source(output valid, red_level, green_level, blue_level, cold_level,
                 warm_level, input ready);
  modport sink(input valid, red_level, green_level, blue_level, cold_level,
               warm_level, output ready);
endinterface

interface ldfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_begin;
  logic       frame_finish;
  logic       run_last;

  modport source(output valid, frame_byte, frame_begin, frame_finish, run_last,
                 input ready);
  modport sink(input valid, frame_byte, frame_begin, frame_finish, run_last,
               output ready);
endinterface
`default_nettype wire

// File: rtl/ldfc_lane.sv
// One channel lane: holds the stored level and flags change / nonzero.
// Depends on ldfc_pkg.
`default_nettype none
module ldfc_lane (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire ldfc_pkg::level_t     level,
  output ldfc_pkg::lane_flags_t     flags
);
  import ldfc_pkg::*;

  level_t stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else if (accept) begin
      stored <= level;
    end
  end

  assign flags.changed = (level != stored);
  assign flags.nonzero = (level != '0);

endmodule
`default_nettype wire

// File: rtl/ldfc_merge.sv
// Merge stage: combines lane flags into a frame kind and registers the
// frame descriptor as a one-entry skid slot. Depends on ldfc_pkg.
`default_nettype none
module ldfc_merge (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire ldfc_pkg::lane_flags_t [ldfc_pkg::NUM_CH-1:0] flags,
  input  wire logic [ldfc_pkg::NUM_CH-1:0][9:0]   levels,
  input  wire logic                               take,
  output logic                                    pend_valid,
  output ldfc_pkg::frame_desc_t                   pend_desc
);
  import ldfc_pkg::*;

  logic  any_changed;
  logic  colour_on;
  logic  white_on;
  kind_t kind;

  always_comb begin
    any_changed = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      any_changed = any_changed | flags[i].changed;
    end
    colour_on = flags[0].nonzero | flags[1].nonzero | flags[2].nonzero;
    white_on  = flags[3].nonzero | flags[4].nonzero;
    if (!colour_on && !white_on) begin
      kind = KIND_OFF;
    end else if (!colour_on) begin
      kind = KIND_WHITE;
    end else if (!white_on) begin
      kind = KIND_COLOR;
    end else begin
      kind = KIND_MIXED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && any_changed) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && any_changed) begin
      pend_desc.kind   <= kind;
      pend_desc.levels <= levels;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ldfc_serializer.sv
// Frame serializer: walks one descriptor out as 12 or 24 byte transactions.
// Depends on ldfc_pkg and ldfc_if.
`default_nettype none
module ldfc_serializer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ldfc_pkg::cfg_t        cfg,
  input  wire logic                  pend_valid,
  input  wire ldfc_pkg::frame_desc_t pend_desc,
  output logic                       take,
  ldfc_out_if.source                 out_ch
);
  import ldfc_pkg::*;

  localparam logic [CNT_W-1:0] LAST_ONE = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] LAST_TWO = CNT_W'(2 * FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] FLEN     = CNT_W'(FRAME_LEN);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  frame_desc_t       desc;

  logic              is_off;
  logic              last_byte;
  logic              step;
  logic              done;
  logic              second;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  lvl_pos;
  logic [CH_W-1:0]   ch;
  level_t            lvl;
  logic [7:0]        mode_addr;
  logic [7:0]        cur;
  logic [7:0]        byte_val;

  assign is_off    = (desc.kind == KIND_OFF);
  assign last_byte = (cnt == (is_off ? LAST_TWO : LAST_ONE));
  assign step      = busy & out_ch.ready;
  assign done      = step & last_byte;
  assign take      = pend_valid & (~busy | done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc <= pend_desc;
    end
  end

  // position within the current frame
  assign second  = (cnt >= FLEN);
  assign idx     = second ? IDX_W'(cnt - FLEN) : IDX_W'(cnt);
  assign lvl_pos = idx - IDX_W'(2);
  assign ch      = CH_W'(lvl_pos >> 1);
  assign lvl     = desc.levels[ch];

  always_comb begin
    case (desc.kind)
      KIND_WHITE: begin
        mode_addr = ADDR_WHITE;
        cur       = {4'h0, cfg.white_current};
      end
      KIND_COLOR: begin
        mode_addr = ADDR_COLOR;
        cur       = {cfg.color_current, 4'h0};
      end
      KIND_MIXED: begin
        mode_addr = ADDR_ALL;
        cur       = {cfg.color_current, cfg.white_current};
      end
      default: begin
        mode_addr = second ? ADDR_STANDBY : ADDR_ALL;
        cur       = 8'h00;
      end
    endcase

    if (idx == '0) begin
      byte_val = cfg.model_base + mode_addr;
    end else if (is_off) begin
      byte_val = 8'h00;
    end else if (idx == IDX_W'(1)) begin
      byte_val = cur;
    end else if (!lvl_pos[0]) begin
      byte_val = {6'b0, lvl[9:8]};
    end else begin
      byte_val = lvl[7:0];
    end
  end

  assign out_ch.valid        = busy;
  assign out_ch.frame_byte   = byte_val;
  assign out_ch.frame_begin  = (idx == '0);
  assign out_ch.frame_finish = (idx == IDX_W'(FRAME_LEN - 1));
  assign out_ch.run_last     = last_byte;

endmodule
`default_nettype wire

// File: rtl/led_driver_frame_composer.sv
// Top level of the LED driver frame composer: APB register file, five
// channel lanes, merge stage and byte serializer.
// Depends on ldfc_pkg, ldfc_if, ldfc_lane, ldfc_merge, ldfc_serializer.
//
// Usage:
//  - in_ch carries five 10-bit levels per transaction. Each lane compares
//    its level with the one it stored and stores the new one. An item with
//    no change produces no output; any change builds one frame descriptor.
//  - out_ch carries one frame byte per transaction, with frame_begin on the
//    first byte, frame_finish on the twelfth, run_last on the last byte of
//    the item. A normal item gives 12 bytes; all-zero levels give 24 (an
//    all-off frame, then a standby frame).
//  - An item's descriptor goes through the skid slot into the serializer.
//  - Throughput: one byte per cycle while out_ch.ready is high, 12 or 24
//    bytes per changing item. A descriptor skid slot in the merge stage
//    lets the next item enter while a frame is going out.
//  - Stall: when out_ch.ready is low the current byte holds; once the skid
//    slot is full, in_ch.ready drops until the serializer takes it.
//  - Reset (rst, synchronous): stored levels clear to zero, no frame
//    pending, model_base=0, color_current=2, white_current=4.
//  - Registers at byte addresses 0, 4, 8; write only while idle.
`default_nettype none
module led_driver_frame_composer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ldfc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  ldfc_in_if.sink                            in_ch,
  ldfc_out_if.source                         out_ch
);
  import ldfc_pkg::*;

  cfg_t                           cfg;
  logic                           cfg_wr;
  logic [1:0]                     reg_idx;

  logic                           accept;
  logic                           take;
  logic                           pend_valid;
  frame_desc_t                    pend_desc;
  lane_flags_t [NUM_CH-1:0]       flags;
  logic [NUM_CH-1:0][9:0]         levels;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.model_base    <= 8'd0;
      cfg.color_current <= 4'd2;
      cfg.white_current <= 4'd4;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODEL_BASE:    cfg.model_base    <= pwdata[7:0];
        REG_COLOR_CURRENT: cfg.color_current <= pwdata[3:0];
        REG_WHITE_CURRENT: cfg.white_current <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODEL_BASE:    prdata = {24'b0, cfg.model_base};
      REG_COLOR_CURRENT: prdata = {28'b0, cfg.color_current};
      REG_WHITE_CURRENT: prdata = {28'b0, cfg.white_current};
      default:           prdata = 32'b0;
    endcase
  end

  // ---- input handshake: accept while the skid slot is free or draining ----
  assign in_ch.ready = ~pend_valid | take;
  assign accept      = in_ch.valid & in_ch.ready;

  assign levels[0] = in_ch.red_level;
  assign levels[1] = in_ch.green_level;
  assign levels[2] = in_ch.blue_level;
  assign levels[3] = in_ch.cold_level;
  assign levels[4] = in_ch.warm_level;

  // ---- channel lanes ----
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    ldfc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .level  (levels[g]),
      .flags  (flags[g])
    );
  end

  // ---- merge: frame kind and pending descriptor ----
  ldfc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .flags      (flags),
    .levels     (levels),
    .take       (take),
    .pend_valid (pend_valid),
    .pend_desc  (pend_desc)
  );

  // ---- byte serializer ----
  ldfc_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pend_valid (pend_valid),
    .pend_desc  (pend_desc),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_driver_frame_composer.
// Needs ldfc_pkg, the ldfc_in_if and ldfc_out_if interfaces, and the RTL of the block.
module tb;
  import ldfc_pkg::*;

  // Five levels packed by channel: 0 red, 1 green, 2 blue, 3 cold, 4 warm.
  typedef logic [NUM_CH-1:0][9:0] chan_levels_t;

  // One expected output transaction.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_begin;
    logic       frame_finish;
    logic       run_last;
  } frame_byte_t;

  // Directed stimulus row. When typed is set, the frame header is written
  // out by hand: nfr frames (0, 1 or 2), address bytes and current byte.
  typedef struct packed {
    logic         typed;
    logic [1:0]   nfr;
    logic [7:0]   addr_a;
    logic [7:0]   addr_b;
    logic [7:0]   cur;
    chan_levels_t lv;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 8;     // margin for items still in flight, be generous
  localparam int RAND_PHASES    = 5;
  localparam int PHASE_ITEMS    = 100;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ldfc_in_if  in_ch();
  ldfc_out_if out_ch();

  led_driver_frame_composer i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Shadow of the block: stored levels and the three registers.
  chan_levels_t held_lv;
  cfg_t         cfg_shadow;

  frame_byte_t  frame_q[$];      // bytes still owed by the block
  stim_row_t    dir_rows[$];

  int  err_cnt      = 0;
  int  n_items      = 0;
  int  n_unchanged  = 0;
  int  n_bytes      = 0;
  int  n_reg_wr     = 0;
  int  idle_cnt     = 0;
  bit  src_idle_on  = 1'b1;      // sender gaps enabled
  bit  snk_idle_on  = 1'b1;      // receiver stalls enabled
  bit  hold_go      = 1'b0;      // sender asks the receiver for a long hold

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line per failure, plus a running count
  // ---------------------------------------------------------------------------
  task automatic report(string what, int unsigned got, int unsigned want);
    err_cnt++;
    $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h (byte #%0d)", $realtime, what, got,
             want, n_bytes);
  endtask

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------
  // Queue the twelve bytes of one frame. Levels go out high byte first.
  function automatic void push_frame(logic [7:0] addr, logic [7:0] cur, chan_levels_t lv,
                                     bit last_frame);
    frame_byte_t fb;
    int ch;
    for (int i = 0; i < FRAME_LEN; i++) begin
      ch = (i - 2) / 2;
      if (i == 0) fb.frame_byte = addr;
      else if (i == 1) fb.frame_byte = cur;
      else if (i % 2 == 0) fb.frame_byte = {6'b0, lv[ch][9:8]};
      else fb.frame_byte = lv[ch][7:0];
      fb.frame_begin  = (i == 0);
      fb.frame_finish = (i == FRAME_LEN - 1);
      fb.run_last     = last_frame && (i == FRAME_LEN - 1);
      frame_q.push_back(fb);
    end
  endfunction

  // Update the stored levels for one accepted transaction and queue the bytes
  // it should produce. A typed row supplies its own header bytes.
  function automatic void predict_frames(chan_levels_t lv, bit use_row, stim_row_t row);
    logic       changed;
    logic       colour_on;
    logic       white_on;
    kind_t      kind;
    logic [7:0] addr;
    logic [7:0] cur;
    changed = (lv != held_lv);
    held_lv = lv;
    n_items++;
    if (!changed) n_unchanged++;
    if (use_row) begin
      if (row.nfr == 2'd1) begin
        push_frame(row.addr_a, row.cur, lv, 1'b1);
      end else if (row.nfr == 2'd2) begin
        push_frame(row.addr_a, 8'h00, '0, 1'b0);
        push_frame(row.addr_b, 8'h00, '0, 1'b1);
      end
      return;
    end
    if (!changed) return;
    colour_on = (lv[0] != 0) || (lv[1] != 0) || (lv[2] != 0);
    white_on  = (lv[3] != 0) || (lv[4] != 0);
    if (!colour_on && !white_on) kind = KIND_OFF;
    else if (!colour_on) kind = KIND_WHITE;
    else if (!white_on) kind = KIND_COLOR;
    else kind = KIND_MIXED;
    case (kind)
      KIND_OFF: begin
        // all-off frame, then standby; both carry zeros after the address
        addr = cfg_shadow.model_base + ADDR_ALL;
        push_frame(addr, 8'h00, '0, 1'b0);
        addr = cfg_shadow.model_base + ADDR_STANDBY;
        push_frame(addr, 8'h00, '0, 1'b1);
      end
      KIND_WHITE: begin
        addr = cfg_shadow.model_base + ADDR_WHITE;
        cur  = {4'h0, cfg_shadow.white_current};
        push_frame(addr, cur, lv, 1'b1);
      end
      KIND_COLOR: begin
        addr = cfg_shadow.model_base + ADDR_COLOR;
        cur  = {cfg_shadow.color_current, 4'h0};
        push_frame(addr, cur, lv, 1'b1);
      end
      default: begin
        addr = cfg_shadow.model_base + ADDR_ALL;
        cur  = {cfg_shadow.color_current, cfg_shadow.white_current};
        push_frame(addr, cur, lv, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. All tasks below start and end on a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_levels(chan_levels_t lv, bit use_row, stim_row_t row);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.red_level   <= lv[0];
    in_ch.green_level <= lv[1];
    in_ch.blue_level  <= lv[2];
    in_ch.cold_level  <= lv[3];
    in_ch.warm_level  <= lv[4];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transaction taken at this edge
    predict_frames(lv, use_row, row);
    @(negedge clk);
  endtask

  // Block is idle once every owed byte came out and the settle wait for any
  // unchanged item still in flight is over.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, then the bus goes idle.
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    n_reg_wr++;
  endtask

  task automatic reg_check(logic [1:0] idx, logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== want) report($sformatf("register %0d readback", idx), got, want);
  endtask

  // Write all three registers with junk in the unused upper bits, which the
  // block must drop, then read each back.
  task automatic set_config(logic [7:0] mb, logic [3:0] cc, logic [3:0] wc);
    wait_idle();
    reg_write(REG_MODEL_BASE,    {24'($urandom_range(0, 16777215)), mb});
    reg_write(REG_COLOR_CURRENT, {28'($urandom()), cc});
    reg_write(REG_WHITE_CURRENT, {28'($urandom()), wc});
    cfg_shadow.model_base    = mb;
    cfg_shadow.color_current = cc;
    cfg_shadow.white_current = wc;
    reg_check(REG_MODEL_BASE,    {24'h0, mb});
    reg_check(REG_COLOR_CURRENT, {28'h0, cc});
    reg_check(REG_WHITE_CURRENT, {28'h0, wc});
  endtask

  function automatic chan_levels_t mk_levels(logic [9:0] r, logic [9:0] g, logic [9:0] b,
                                             logic [9:0] c, logic [9:0] w);
    chan_levels_t lv;
    lv[0] = r;
    lv[1] = g;
    lv[2] = b;
    lv[3] = c;
    lv[4] = w;
    return lv;
  endfunction

  function automatic void add_row(bit typed, logic [1:0] nfr, logic [7:0] addr_a,
                                  logic [7:0] addr_b, logic [7:0] cur, chan_levels_t lv);
    stim_row_t row;
    row.typed  = typed;
    row.nfr    = nfr;
    row.addr_a = addr_a;
    row.addr_b = addr_b;
    row.cur    = cur;
    row.lv     = lv;
    dir_rows.push_back(row);
  endfunction

  // Random level, weighted toward the two ends of the range.
  function automatic logic [9:0] rand_level();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 10'd0;
    if (pick == 1) return 10'h3FF;
    return 10'($urandom_range(0, 1023));
  endfunction

  // Random item mix: repeats, all-zero, colour only, white only, mixed,
  // and single-channel nudges of the last levels.
  function automatic chan_levels_t rand_item();
    chan_levels_t lv;
    int pick;
    pick = $urandom_range(0, 99);
    lv = mk_levels(rand_level(), rand_level(), rand_level(), rand_level(), rand_level());
    if (pick < 10) begin
      lv = held_lv;
    end else if (pick < 20) begin
      lv = held_lv;
      lv[CH_W'($urandom_range(0, NUM_CH - 1))] = rand_level();
    end else if (pick < 32) begin
      lv = '0;
    end else if (pick < 50) begin
      lv[3] = 10'd0;
      lv[4] = 10'd0;
    end else if (pick < 68) begin
      lv[0] = 10'd0;
      lv[1] = 10'd0;
      lv[2] = 10'd0;
    end
    return lv;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: receiver stalls in bursts, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Output checker: each byte against the oldest expectation.
  always @(posedge clk) begin : byte_checker
    frame_byte_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (frame_q.size() == 0) begin
        report("byte with nothing owed", out_ch.frame_byte, 0);
      end else begin
        want = frame_q.pop_front();
        if (out_ch.frame_byte !== want.frame_byte)
          report("frame_byte", out_ch.frame_byte, want.frame_byte);
        if (out_ch.frame_begin !== want.frame_begin)
          report("frame_begin", out_ch.frame_begin, want.frame_begin);
        if (out_ch.frame_finish !== want.frame_finish)
          report("frame_finish", out_ch.frame_finish, want.frame_finish);
        if (out_ch.run_last !== want.run_last)
          report("run_last", out_ch.run_last, want.run_last);
      end
      n_bytes++;
    end
  end

  // Watchdog: too long with no transaction on any port ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel || rst) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles, %0d bytes owed", $realtime,
                 idle_cnt, frame_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_row_t no_row;
    int split;
    no_row  = '0;
    held_lv = '0;
    cfg_shadow.model_base    = 8'h00;
    cfg_shadow.color_current = 4'h2;
    cfg_shadow.white_current = 4'h4;

    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid       = 1'b0;
    in_ch.red_level   = '0;
    in_ch.green_level = '0;
    in_ch.blue_level  = '0;
    in_ch.cold_level  = '0;
    in_ch.warm_level  = '0;

    // Directed table, first half under reset registers (base 0, currents 2 and 4).
    add_row(1, 0, 8'h00, 8'h00, 8'h00, mk_levels(0, 0, 0, 0, 0));         // same as reset
    add_row(1, 1, 8'h08, 8'h00, 8'h20, mk_levels(10'h3FF, 0, 0, 0, 0));   // colour only
    add_row(1, 0, 8'h00, 8'h00, 8'h00, mk_levels(10'h3FF, 0, 0, 0, 0));   // unchanged
    add_row(1, 1, 8'h10, 8'h00, 8'h04, mk_levels(0, 0, 0, 10'h3FF, 0));   // white only
    add_row(1, 1, 8'h10, 8'h00, 8'h04, mk_levels(0, 0, 0, 0, 10'h001));
    add_row(1, 1, 8'h18, 8'h00, 8'h24,
            mk_levels(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF));      // mixed, all max
    add_row(1, 2, 8'h18, 8'h00, 8'h00, mk_levels(0, 0, 0, 0, 0));         // off + standby
    add_row(0, 0, 0, 0, 0, mk_levels(0, 10'h100, 0, 0, 0));
    add_row(0, 0, 0, 0, 0, mk_levels(0, 0, 10'h0FF, 0, 10'h300));
    add_row(0, 0, 0, 0, 0, mk_levels(10'h2AA, 10'h155, 10'h3C3, 10'h03C, 10'h200));
    add_row(0, 0, 0, 0, 0, mk_levels(10'h2AB, 10'h155, 10'h3C3, 10'h03C, 10'h200));
    add_row(1, 2, 8'h18, 8'h00, 8'h00, mk_levels(0, 0, 0, 0, 0));
    add_row(1, 0, 8'h00, 8'h00, 8'h00, mk_levels(0, 0, 0, 0, 0));         // zero repeated
    split = dir_rows.size();
    // Second half under base 0xFF and both currents 0xF: addresses wrap.
    add_row(1, 1, 8'h17, 8'h00, 8'hFF,
            mk_levels(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF));
    add_row(1, 1, 8'h07, 8'h00, 8'hF0, mk_levels(10'h005, 0, 0, 0, 0));
    add_row(1, 1, 8'h0F, 8'h00, 8'h0F, mk_levels(0, 0, 0, 10'h3FF, 10'h3FF));
    add_row(1, 2, 8'h17, 8'hFF, 8'h00, mk_levels(0, 0, 0, 0, 0));
    add_row(0, 0, 0, 0, 0, mk_levels(10'h001, 10'h200, 0, 0, 10'h3FE));
    add_row(1, 0, 8'h00, 8'h00, 8'h00, mk_levels(10'h001, 10'h200, 0, 0, 10'h3FE));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == split) set_config(8'hFF, 4'hF, 4'hF);
      send_levels(dir_rows[i].lv, dir_rows[i].typed, dir_rows[i]);
    end

    // Random phases, each under its own register setting. The third one
    // carries the long receiver hold so the skid slot fills and in_ch stalls.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_config(8'h00, 4'h0, 4'h0);
        2: set_config(8'hF0, 4'hF, 4'h0);
        default: set_config(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)));
      endcase
      if (p == RAND_PHASES - 1) begin
        // no idling on either side at the end
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 10) hold_go = 1'b1;
        send_levels(rand_item(), 1'b0, no_row);
      end
    end

    in_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d level transactions (%0d unchanged) and %0d frame bytes,",
             n_items, n_unchanged, n_bytes);
    $display("across %0d register writes with zero, maximum and random settings.", n_reg_wr);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
